/* rtl/lcsr_pkg.sv */
`timescale 1ns / 1ps
// lcsr_pkg: shared types and constants of the load cell serial reader
// no dependencies; imported by lcsr_seq, lcsr_post and the top module

package lcsr_pkg;

  // pin sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_HIGH,
    PH_LOW
  } phase_t;

  // result engine states
  typedef enum logic [2:0] {
    PS_IDLE,
    PS_LDA,
    PS_AVG,
    PS_DIFF,
    PS_LDW,
    PS_WGT,
    PS_FIN
  } post_state_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT  = 3'd0,
    REG_READY_TIMEOUT = 3'd1,
    REG_HALF_PERIOD   = 3'd2,
    REG_ZERO_OFFSET   = 3'd3,
    REG_SCALE_DIVISOR = 3'd4
  } cfg_idx_t;

  // per-tick status from the sequencer
  typedef struct packed {
    logic sck;
    logic busy;
    logic run_end;
  } seq_stat_t;

  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int WAIT_W      = 24;
  localparam int OFS_W       = 32;
  localparam int DIFF_W      = OFS_W + 2;
  localparam int MAG_W       = OFS_W + 1;
  localparam int FRAC_SH     = 24;
  localparam int WGT_W       = 48;
  localparam int RAW_W       = 24;
  localparam int DVS_W       = 32;
  localparam int DVD_W       = MAG_W + FRAC_SH;
  localparam int IN_DATA_W   = 8;
  localparam int OUT_FIELD_W = 3 + RAW_W + WGT_W + 2;
  localparam int OUT_DATA_W  = 80;

  localparam logic [WAIT_W-1:0] RST_READY_TIMEOUT = 24'd600000;
  localparam logic [OFS_W-1:0]  RST_SCALE_DIVISOR = 32'd65536;

  localparam logic [WGT_W-1:0] WGT_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [WGT_W-1:0] WGT_MIN = 48'h8000_0000_0000;

endpackage

/* rtl/lcsr_bit_div.sv */
`timescale 1ns / 1ps
// lcsr_bit_div: restoring divider, one quotient bit per cycle
// depends on nothing but its parameters

module lcsr_bit_div #(
  parameter int DVD_W = 57,
  parameter int DVS_W = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVD_W-1:0] quo_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] trial;
  logic             fits;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    rem_sh = {rem_r, quo_r[DVD_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, dvs_r};
    fits   = !trial[DVS_W+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_W'(1));
      if (load) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], fits};
      rem_r <= fits ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

  a_load_starts : assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (busy_r && cnt_r == CNT_W'(DVD_W)))
    else $error("divider did not start a full pass on load");

  a_done_after_pass : assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (!busy_r && $past(busy_r)))
    else $error("divider done without a finished pass");

endmodule

/* rtl/lcsr_seq.sv */
`timescale 1ns / 1ps
// lcsr_seq: per-tick pin sequencer, serial data shift register and sample sum
// depends on lcsr_pkg

module lcsr_seq
  import lcsr_pkg::*;
#(
  parameter int DATA_BITS  = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick_en,
  input  logic                           dout,
  input  logic                           start_req,
  input  logic                           power_down,
  input  logic [COUNT_BITS-1:0]          sample_count,
  input  logic [WAIT_W-1:0]              ready_timeout,
  input  logic [COUNT_BITS-1:0]          half_period,
  output seq_stat_t                      stat,
  output logic [DATA_BITS+COUNT_BITS-1:0] sum,
  output logic [COUNT_BITS-1:0]          run_n,
  output logic                           run_to
);

  localparam int SUM_W  = DATA_BITS + COUNT_BITS;
  localparam int BIDX_W = $clog2(DATA_BITS + 2);
  localparam logic [DATA_BITS-1:0] SIGN_FLIP = {1'b1, {(DATA_BITS-1){1'b0}}};

  phase_t                phase_r, phase_nxt;
  logic [WAIT_W-1:0]     wait_cnt_r, wait_cnt_nxt;
  logic [COUNT_BITS-1:0] pulse_cnt_r, pulse_cnt_nxt;
  logic [BIDX_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [DATA_BITS-1:0]  shift_r, shift_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] smp_r, smp_nxt;
  logic                  run_to_r, run_to_nxt;

  logic                  take_sample;
  logic [DATA_BITS-1:0]  end_word;
  logic [BIDX_W-1:0]     bit_inc;
  logic [COUNT_BITS-1:0] smp_inc;
  logic                  sck;
  logic                  run_end;

  // a zero count runs one conversion
  assign run_n = (sample_count == '0) ? COUNT_BITS'(1) : sample_count;

  always_comb begin
    phase_nxt     = phase_r;
    wait_cnt_nxt  = wait_cnt_r;
    pulse_cnt_nxt = pulse_cnt_r;
    bit_idx_nxt   = bit_idx_r;
    shift_nxt     = shift_r;
    sum_nxt       = sum_r;
    smp_nxt       = smp_r;
    run_to_nxt    = run_to_r;
    take_sample   = 1'b0;
    end_word      = '0;
    sck           = 1'b0;
    run_end       = 1'b0;
    bit_inc       = bit_idx_r + BIDX_W'(1);
    smp_inc       = smp_r + COUNT_BITS'(1);

    case (phase_r)
      PH_IDLE: begin
        // power down holds the clock high and blocks a start
        if (power_down) begin
          sck = 1'b1;
        end else if (start_req) begin
          sum_nxt      = '0;
          smp_nxt      = '0;
          run_to_nxt   = 1'b0;
          wait_cnt_nxt = '0;
          phase_nxt    = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (!dout) begin
          bit_idx_nxt   = '0;
          shift_nxt     = '0;
          pulse_cnt_nxt = COUNT_BITS'(1);
          phase_nxt     = PH_HIGH;
          sck           = 1'b1;
        end else if (wait_cnt_r >= ready_timeout) begin
          // timed-out sample counts as zero, no sign flip
          run_to_nxt  = 1'b1;
          take_sample = 1'b1;
        end else begin
          wait_cnt_nxt = wait_cnt_r + WAIT_W'(1);
        end
      end
      PH_HIGH: begin
        if (pulse_cnt_r < half_period) begin
          pulse_cnt_nxt = pulse_cnt_r + COUNT_BITS'(1);
          sck           = 1'b1;
        end else begin
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        // sample in the low tick, msb first; the extra pulse is not sampled
        if (bit_idx_r < BIDX_W'(DATA_BITS)) begin
          shift_nxt = {shift_r[DATA_BITS-2:0], dout};
        end
        bit_idx_nxt = bit_inc;
        if (bit_inc > BIDX_W'(DATA_BITS)) begin
          take_sample = 1'b1;
          end_word    = shift_nxt ^ SIGN_FLIP;
        end else begin
          pulse_cnt_nxt = COUNT_BITS'(1);
          phase_nxt     = PH_HIGH;
          sck           = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (take_sample) begin
      sum_nxt = sum_r + SUM_W'(end_word);
      smp_nxt = smp_inc;
      if (smp_inc >= run_n) begin
        run_end   = 1'b1;
        phase_nxt = PH_IDLE;
      end else begin
        phase_nxt    = PH_WAIT;
        wait_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_cnt_r  <= '0;
      pulse_cnt_r <= '0;
      bit_idx_r   <= '0;
      smp_r       <= '0;
      run_to_r    <= 1'b0;
    end else if (tick_en) begin
      phase_r     <= phase_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
      pulse_cnt_r <= pulse_cnt_nxt;
      bit_idx_r   <= bit_idx_nxt;
      smp_r       <= smp_nxt;
      run_to_r    <= run_to_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      shift_r <= shift_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign stat.sck     = sck;
  assign stat.busy    = (phase_nxt != PH_IDLE);
  assign stat.run_end = run_end;
  assign sum          = sum_r;
  assign run_to       = run_to_r;

endmodule

/* rtl/lcsr_post.sv */
`timescale 1ns / 1ps
// lcsr_post: averaging and weight scaling over one shared serial divider
// depends on lcsr_pkg and lcsr_bit_div

module lcsr_post
  import lcsr_pkg::*;
#(
  parameter int DATA_BITS  = 24,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [DATA_BITS+COUNT_BITS-1:0] sum,
  input  logic [COUNT_BITS-1:0]           run_n,
  input  logic                            run_to,
  input  logic [OFS_W-1:0]                zero_offset,
  input  logic [DVS_W-1:0]                scale_divisor,
  input  logic                            ack,
  output logic                            busy,
  output logic                            fin,
  output logic [DATA_BITS-1:0]            avg,
  output logic [WGT_W-1:0]                weight,
  output logic                            timed_out,
  output logic                            scale_error
);

  post_state_t state_r, state_nxt;

  logic [DATA_BITS-1:0] avg_latch_r;
  logic [WGT_W-1:0]     wgt_latch_r;
  logic [1:0]           flags_r;
  logic [DIFF_W-1:0]    diff_r;
  logic                 zdiv_r;

  logic                 div_load;
  logic                 div_busy;
  logic                 div_done;
  logic [DVD_W-1:0]     div_dvd;
  logic [DVS_W-1:0]     div_dvs;
  logic [DVD_W-1:0]     quo;

  logic [DIFF_W-1:0]    diff_abs;
  logic [DVS_W-1:0]     scale_mag;
  logic [WGT_W-1:0]     quo_lo;
  logic                 quo_big;
  logic                 neg;
  logic [WGT_W-1:0]     wgt_nxt;

  lcsr_bit_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (div_load),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PS_IDLE: if (start) state_nxt = PS_LDA;
      PS_LDA:  state_nxt = PS_AVG;
      PS_AVG:  if (div_done) state_nxt = PS_DIFF;
      PS_DIFF: state_nxt = PS_LDW;
      PS_LDW:  state_nxt = PS_WGT;
      PS_WGT:  if (div_done) state_nxt = PS_FIN;
      PS_FIN:  if (ack) state_nxt = PS_IDLE;
      default: state_nxt = PS_IDLE;
    endcase
  end

  // divider operands: sum over count, then |difference| in q24 over |divisor|
  always_comb begin
    neg       = diff_r[DIFF_W-1];
    diff_abs  = neg ? (~diff_r + DIFF_W'(1)) : diff_r;
    scale_mag = scale_divisor[DVS_W-1] ? (~scale_divisor + DVS_W'(1)) : scale_divisor;
    div_load  = (state_r == PS_LDA) || (state_r == PS_LDW);
    if (state_r == PS_LDA) begin
      div_dvd = DVD_W'(sum);
      div_dvs = DVS_W'(run_n);
    end else begin
      div_dvd = {diff_abs[MAG_W-1:0], {FRAC_SH{1'b0}}};
      div_dvs = scale_mag;
    end
  end

  // truncated quotient, saturated to the signed weight range
  always_comb begin
    quo_lo  = quo[WGT_W-1:0];
    quo_big = |quo[DVD_W-1:WGT_W-1];
    if (zdiv_r) begin
      wgt_nxt = neg ? WGT_MIN : WGT_MAX;
    end else if (neg) begin
      wgt_nxt = quo_big ? WGT_MIN : (~quo_lo + WGT_W'(1));
    end else begin
      wgt_nxt = quo_big ? WGT_MAX : quo_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PS_IDLE;
      avg_latch_r <= '0;
      wgt_latch_r <= '0;
      flags_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == PS_AVG && div_done) begin
        avg_latch_r <= quo[DATA_BITS-1:0];
      end
      if (state_r == PS_WGT && div_done) begin
        wgt_latch_r <= wgt_nxt;
        flags_r     <= {zdiv_r, run_to};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == PS_DIFF) begin
      diff_r <= DIFF_W'(avg_latch_r)
                - {{(DIFF_W-OFS_W){zero_offset[OFS_W-1]}}, zero_offset};
    end
    if (state_r == PS_LDW) begin
      zdiv_r <= (scale_divisor == '0);
    end
  end

  assign busy        = (state_r != PS_IDLE) || div_busy;
  assign fin         = (state_r == PS_FIN);
  assign avg         = avg_latch_r;
  assign weight      = wgt_latch_r;
  assign timed_out   = flags_r[0];
  assign scale_error = flags_r[1];

endmodule

/* rtl/load_cell_serial_reader_avg_top.sv */
`timescale 1ns / 1ps
// load_cell_serial_reader_avg_top: stream wrapper, config registers, result register
// depends on lcsr_pkg, lcsr_seq, lcsr_post (and lcsr_bit_div below it)

// Reader for a serial 24-bit load-cell converter. Every input word is one
// 1 us tick carrying the sampled data pin plus start and power-down requests,
// and every input word produces exactly one output word with the serial clock
// level to drive, the busy and done flags and the latched results. On start
// the block runs sample_count conversions: wait for data low (ready_timeout
// ticks, after which the sample counts as zero and timed_out is set), clock
// the data bits msb first with half_period ticks high and one tick low per
// pulse, then one extra pulse. Samples are flipped to offset binary and
// summed; the average and the weight, (average - zero_offset) / |scale_divisor|
// in signed q24 saturated to 48 bits, come out of one bit-serial divider.
// A zero divisor saturates the weight and sets scale_error.
// Rate: ticks that do not finish a run stream at one word per clock while the
// output is taken. The tick that finishes a run waits for the serial divider,
// which produces one quotient bit per cycle and runs once for the average and
// once for the weight, and for its result word to be taken; in_tready stays
// low during that time. Config writes are taken any time and must only be
// issued while no run is in progress.

module load_cell_serial_reader_avg_top
  import lcsr_pkg::*;
#(
  parameter int DATA_BITS  = 24,  // converter word width, 16 to 32
  parameter int COUNT_BITS = 16   // counter width for sample count and half period, 4 to 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // dout, start_req, power_down, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // sck, busy_res, done_res, raw_average[23:0],
                                            // weight[47:0], timed_out, scale_error, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W = DATA_BITS + COUNT_BITS;

  // output word, lowest field last
  typedef struct packed {
    logic             scale_error;
    logic             timed_out;
    logic [WGT_W-1:0] weight;
    logic [RAW_W-1:0] raw_average;
    logic             done_res;
    logic             busy_res;
    logic             sck;
  } out_word_t;

  // configuration registers
  logic [COUNT_BITS-1:0] sample_count_r;
  logic [WAIT_W-1:0]     ready_timeout_r;
  logic [COUNT_BITS-1:0] half_period_r;
  logic [OFS_W-1:0]      zero_offset_r;
  logic [DVS_W-1:0]      scale_divisor_r;

  // result register
  out_word_t out_word_r;
  logic      out_valid_r;

  seq_stat_t             stat;
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] run_n;
  logic                  run_to;

  logic                  post_busy;
  logic                  post_fin;
  logic [DATA_BITS-1:0]  avg;
  logic [WGT_W-1:0]      weight;
  logic                  timed_out;
  logic                  scale_error;

  logic                  out_free;
  logic                  in_acc;
  out_word_t             tick_word;
  out_word_t             fin_word;

  // config writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r  <= COUNT_BITS'(1);
      ready_timeout_r <= RST_READY_TIMEOUT;
      half_period_r   <= COUNT_BITS'(1);
      zero_offset_r   <= '0;
      scale_divisor_r <= RST_SCALE_DIVISOR;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SAMPLE_COUNT:  sample_count_r  <= cfg_wdata[COUNT_BITS-1:0];
        REG_READY_TIMEOUT: ready_timeout_r <= cfg_wdata[WAIT_W-1:0];
        REG_HALF_PERIOD:   half_period_r   <= cfg_wdata[COUNT_BITS-1:0];
        REG_ZERO_OFFSET:   zero_offset_r   <= cfg_wdata[OFS_W-1:0];
        REG_SCALE_DIVISOR: scale_divisor_r <= cfg_wdata[DVS_W-1:0];
        default: ;
      endcase
    end
  end

  // result register frees up when empty or taken this cycle
  assign out_free  = !out_valid_r || out_tready;
  // ticks stall while the post block works on a finished run or the result register is held
  assign in_tready = !post_busy && out_free;
  assign in_acc    = in_tvalid && in_tready;

  lcsr_seq #(
    .DATA_BITS  (DATA_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick_en       (in_acc),
    .dout          (in_tdata[0]),
    .start_req     (in_tdata[1]),
    .power_down    (in_tdata[2]),
    .sample_count  (sample_count_r),
    .ready_timeout (ready_timeout_r),
    .half_period   (half_period_r),
    .stat          (stat),
    .sum           (sum),
    .run_n         (run_n),
    .run_to        (run_to)
  );

  lcsr_post #(
    .DATA_BITS  (DATA_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (in_acc && stat.run_end),
    .sum           (sum),
    .run_n         (run_n),
    .run_to        (run_to),
    .zero_offset   (zero_offset_r),
    .scale_divisor (scale_divisor_r),
    .ack           (out_free),
    .busy          (post_busy),
    .fin           (post_fin),
    .avg           (avg),
    .weight        (weight),
    .timed_out     (timed_out),
    .scale_error   (scale_error)
  );

  // plain tick word carries the latched results of the last finished run
  always_comb begin
    tick_word.scale_error = scale_error;
    tick_word.timed_out   = timed_out;
    tick_word.weight      = weight;
    tick_word.raw_average = RAW_W'(avg);
    tick_word.done_res    = 1'b0;
    tick_word.busy_res    = stat.busy;
    tick_word.sck         = stat.sck;

    // run-ending tick: clock low, idle, fresh results
    fin_word          = tick_word;
    fin_word.done_res = 1'b1;
    fin_word.busy_res = 1'b0;
    fin_word.sck      = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && !stat.run_end) begin
      out_valid_r <= 1'b1;
    end else if (post_fin && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && !stat.run_end) begin
      out_word_r <= tick_word;
    end else if (post_fin && out_free) begin
      out_word_r <= fin_word;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_word_r);

  a_run_end_stalls : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && stat.run_end) |=> !in_tready)
    else $error("input taken while a finished run is being scaled");

  a_fin_word : assert property (@(posedge clk) disable iff (!rst_n)
    (post_fin && out_free) |=> (out_tvalid && out_tdata[2] && !out_tdata[1]))
    else $error("finished run did not show as a done, idle word");

  a_tick_word : assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !stat.run_end) |=> (out_tvalid && !out_tdata[2]))
    else $error("plain tick lost or marked done");

endmodule
